[hw/rtl/pidc_pkg.sv]
`default_nettype none

package pidc_pkg;

    // Gains are unsigned fixed point with a fixed 16-bit register width.
    localparam int GAIN_W = 16;

    // Configuration register index width; writes to indexes above the
    // last register are ignored.
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FEED_FWD       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_LIMIT     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_LIMIT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT      = 4'd7;

    localparam int OP_W = 2;

    localparam logic [OP_W-1:0] OP_STEP      = 2'd0;
    localparam logic [OP_W-1:0] OP_CLR_INTEG = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_MEAS = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/pidc_if.sv]
`default_nettype none

interface pidc_in_if
    import pidc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [OP_W-1:0]               opcode;
    logic signed [SAMPLE_BITS-1:0] measured;
    logic signed [SAMPLE_BITS-1:0] setpoint;

    modport source (output valid, output opcode, output measured, output setpoint,
                    input ready);
    modport sink   (input valid, input opcode, input measured, input setpoint,
                    output ready);
endinterface

interface pidc_out_if
#(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

[hw/rtl/pidc_cfg_regs.sv]
`default_nettype none

module pidc_cfg_regs
    import pidc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int CFG_W       = 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [CFG_IDX_W-1:0]          wr_index,
    input  wire logic [CFG_W-1:0]              wr_data,
    output logic [GAIN_W-1:0]                  prop_gain,
    output logic [GAIN_W-1:0]                  integ_gain,
    output logic [GAIN_W-1:0]                  deriv_gain,
    output logic signed [SAMPLE_BITS-1:0]      feed_fwd,
    output logic [SAMPLE_BITS-2:0]             meas_limit,
    output logic [SAMPLE_BITS-2:0]             setpoint_limit,
    output logic [SAMPLE_BITS-2:0]             integ_limit,
    output logic [SAMPLE_BITS-2:0]             out_limit
);

    logic [GAIN_W-1:0]             prop_gain_reg;
    logic [GAIN_W-1:0]             integ_gain_reg;
    logic [GAIN_W-1:0]             deriv_gain_reg;
    logic signed [SAMPLE_BITS-1:0] feed_fwd_reg;
    logic [SAMPLE_BITS-2:0]        meas_limit_reg;
    logic [SAMPLE_BITS-2:0]        setpoint_limit_reg;
    logic [SAMPLE_BITS-2:0]        integ_limit_reg;
    logic [SAMPLE_BITS-2:0]        out_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= '0;
            integ_gain_reg     <= '0;
            deriv_gain_reg     <= '0;
            feed_fwd_reg       <= '0;
            meas_limit_reg     <= '1;
            setpoint_limit_reg <= '1;
            integ_limit_reg    <= '1;
            out_limit_reg      <= '1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_PROP_GAIN:      prop_gain_reg      <= wr_data[GAIN_W-1:0];
                REG_INTEG_GAIN:     integ_gain_reg     <= wr_data[GAIN_W-1:0];
                REG_DERIV_GAIN:     deriv_gain_reg     <= wr_data[GAIN_W-1:0];
                REG_FEED_FWD:       feed_fwd_reg       <= $signed(wr_data[SAMPLE_BITS-1:0]);
                REG_MEAS_LIMIT:     meas_limit_reg     <= wr_data[SAMPLE_BITS-2:0];
                REG_SETPOINT_LIMIT: setpoint_limit_reg <= wr_data[SAMPLE_BITS-2:0];
                REG_INTEG_LIMIT:    integ_limit_reg    <= wr_data[SAMPLE_BITS-2:0];
                REG_OUT_LIMIT:      out_limit_reg      <= wr_data[SAMPLE_BITS-2:0];
                default:            ;
            endcase
        end
    end

    assign prop_gain      = prop_gain_reg;
    assign integ_gain     = integ_gain_reg;
    assign deriv_gain     = deriv_gain_reg;
    assign feed_fwd       = feed_fwd_reg;
    assign meas_limit     = meas_limit_reg;
    assign setpoint_limit = setpoint_limit_reg;
    assign integ_limit    = integ_limit_reg;
    assign out_limit      = out_limit_reg;

endmodule

`default_nettype wire

[hw/rtl/pidc_core.sv]
`default_nettype none

module pidc_core
    import pidc_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [OP_W-1:0]               opcode,
    input  wire logic signed [SAMPLE_BITS-1:0] measured,
    input  wire logic signed [SAMPLE_BITS-1:0] setpoint,
    input  wire logic [GAIN_W-1:0]             prop_gain,
    input  wire logic [GAIN_W-1:0]             integ_gain,
    input  wire logic [GAIN_W-1:0]             deriv_gain,
    input  wire logic signed [SAMPLE_BITS-1:0] feed_fwd,
    input  wire logic [SAMPLE_BITS-2:0]        meas_limit,
    input  wire logic [SAMPLE_BITS-2:0]        setpoint_limit,
    input  wire logic [SAMPLE_BITS-2:0]        integ_limit,
    input  wire logic [SAMPLE_BITS-2:0]        out_limit,
    output logic signed [SAMPLE_BITS-1:0]      drive
);

    localparam int S  = SAMPLE_BITS;
    localparam int F  = GAIN_FRAC_BITS;
    localparam int PW = S + GAIN_W + 2;   // difference times a signed-extended gain
    localparam int SW = PW + 1;           // integrator plus product
    localparam int AW = S + F;            // integrator, Q(S).(F)
    localparam int YW = PW + 2;           // sum of the three terms and feed forward

    logic signed [S-1:0]    last_measured_reg;
    logic signed [AW-1:0]   integ_acc_reg;

    logic signed [S-1:0]    m_lim;
    logic signed [S-1:0]    m_neg;
    logic signed [S-1:0]    sp_lim;
    logic signed [S-1:0]    sp_neg;
    logic signed [S-1:0]    m_c;
    logic signed [S-1:0]    sp_c;
    logic signed [S:0]      err;
    logic signed [S:0]      vel;
    logic signed [GAIN_W:0] pg_s;
    logic signed [GAIN_W:0] ig_s;
    logic signed [GAIN_W:0] dg_s;
    logic signed [PW-1:0]   p_prod;
    logic signed [PW-1:0]   i_prod;
    logic signed [PW-1:0]   d_prod;
    logic signed [SW-1:0]   isum;
    logic signed [SW-1:0]   ilim;
    logic signed [SW-1:0]   isum_c;
    logic signed [AW-1:0]   acc_next;
    logic signed [PW-1:0]   p_term;
    logic signed [PW-1:0]   d_term;
    logic signed [AW-1:0]   i_term;
    logic signed [YW-1:0]   y;
    logic signed [YW-1:0]   olim;
    logic signed [YW-1:0]   y_c;

    // Input clamps. The limits are below half the sample range, so their
    // negation always fits in a sample.
    assign m_lim  = $signed({1'b0, meas_limit});
    assign m_neg  = -m_lim;
    assign sp_lim = $signed({1'b0, setpoint_limit});
    assign sp_neg = -sp_lim;

    always_comb
    begin
        priority if (measured > m_lim)
            m_c = m_lim;
        else if (measured < m_neg)
            m_c = m_neg;
        else
            m_c = measured;

        priority if (setpoint > sp_lim)
            sp_c = sp_lim;
        else if (setpoint < sp_neg)
            sp_c = sp_neg;
        else
            sp_c = setpoint;
    end

    assign err = $signed({sp_c[S-1], sp_c}) - $signed({m_c[S-1], m_c});
    assign vel = $signed({m_c[S-1], m_c})
               - $signed({last_measured_reg[S-1], last_measured_reg});

    assign pg_s = $signed({1'b0, prop_gain});
    assign ig_s = $signed({1'b0, integ_gain});
    assign dg_s = $signed({1'b0, deriv_gain});

    assign p_prod = err * pg_s;
    assign i_prod = err * ig_s;
    assign d_prod = vel * dg_s;

    // Integrator: exact accumulation, then clamp to the limit scaled by
    // the fraction bits.
    assign isum = SW'(integ_acc_reg) + SW'(i_prod);
    assign ilim = $signed(SW'(integ_limit) << F);

    always_comb
    begin
        priority if (isum > ilim)
            isum_c = ilim;
        else if (isum < -ilim)
            isum_c = -ilim;
        else
            isum_c = isum;
    end

    assign acc_next = isum_c[AW-1:0];

    // Arithmetic shifts give the floor of each scaled term.
    assign p_term = p_prod >>> F;
    assign d_term = d_prod >>> F;
    assign i_term = acc_next >>> F;

    assign y    = YW'(p_term) + YW'(i_term) - YW'(d_term) + YW'(feed_fwd);
    assign olim = $signed(YW'(out_limit));

    always_comb
    begin
        priority if (y > olim)
            y_c = olim;
        else if (y < -olim)
            y_c = -olim;
        else
            y_c = y;
    end

    assign drive = y_c[S-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_measured_reg <= '0;
            integ_acc_reg     <= '0;
        end
        else if (step)
        begin
            unique case (opcode)
                OP_STEP:
                begin
                    last_measured_reg <= m_c;
                    integ_acc_reg     <= acc_next;
                end
                OP_CLR_INTEG:
                begin
                    integ_acc_reg <= '0;
                end
                OP_LOAD_MEAS:
                begin
                    // The load takes the raw sample, before the clamp.
                    last_measured_reg <= measured;
                    integ_acc_reg     <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/pid_controller_clamped.sv]
`default_nettype none

// Channel   Direction  Handshake      Payload
// sample    in         valid/ready    opcode, measured, setpoint
// result    out        valid/ready    drive
// wr_*      in         wr_en only     wr_index, wr_data
//
// A sample is registered on transfer and then processed, when the drive
// value is computed and written to the output register; one sample per cycle
// is sustained while the output is not held. The integrator and previous
// measurement update in the same cycle, so each sample sees the last one's
// state. Reset and non-compute opcodes give no result and never wait on the
// output side; a compute step waits only while the output register is held.

module pid_controller_clamped
    import pidc_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 8
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    pidc_in_if.sink                                     sample,
    pidc_out_if.source                                  result,
    input  wire logic                                   wr_en,
    input  wire logic [CFG_IDX_W-1:0]                   wr_index,
    input  wire logic [((SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W)-1:0] wr_data
);

    localparam int CFG_W = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;

    logic [GAIN_W-1:0]             prop_gain;
    logic [GAIN_W-1:0]             integ_gain;
    logic [GAIN_W-1:0]             deriv_gain;
    logic signed [SAMPLE_BITS-1:0] feed_fwd;
    logic [SAMPLE_BITS-2:0]        meas_limit;
    logic [SAMPLE_BITS-2:0]        setpoint_limit;
    logic [SAMPLE_BITS-2:0]        integ_limit;
    logic [SAMPLE_BITS-2:0]        out_limit;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [OP_W-1:0]               s1_op_reg;
    logic signed [SAMPLE_BITS-1:0] s1_meas_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sp_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] drive_reg;
    logic signed [SAMPLE_BITS-1:0] core_drive;
    logic                          s1_fire;
    logic                          s1_result;
    logic                          in_xfer;

    pidc_cfg_regs #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CFG_W       (CFG_W)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .prop_gain      (prop_gain),
        .integ_gain     (integ_gain),
        .deriv_gain     (deriv_gain),
        .feed_fwd       (feed_fwd),
        .meas_limit     (meas_limit),
        .setpoint_limit (setpoint_limit),
        .integ_limit    (integ_limit),
        .out_limit      (out_limit)
    );

    pidc_core #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (s1_fire),
        .opcode         (s1_op_reg),
        .measured       (s1_meas_reg),
        .setpoint       (s1_sp_reg),
        .prop_gain      (prop_gain),
        .integ_gain     (integ_gain),
        .deriv_gain     (deriv_gain),
        .feed_fwd       (feed_fwd),
        .meas_limit     (meas_limit),
        .setpoint_limit (setpoint_limit),
        .integ_limit    (integ_limit),
        .out_limit      (out_limit),
        .drive          (core_drive)
    );

    // Only a compute step produces a result; the others retire even while
    // the output register is held.
    assign s1_result = (s1_op_reg == OP_STEP);
    assign s1_fire   = s1_valid_reg && (!s1_result || !out_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || s1_fire;
    assign in_xfer   = sample.valid && sample.ready;

    assign s1_valid_next  = in_xfer || (s1_valid_reg && !s1_fire);
    assign out_valid_next = (s1_fire && s1_result) || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg   <= sample.opcode;
            s1_meas_reg <= sample.measured;
            s1_sp_reg   <= sample.setpoint;
        end
        if (s1_fire && s1_result)
        begin
            drive_reg <= core_drive;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import pidc_pkg::*;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRAC_BITS     = 8;
    localparam int WR_W          = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;
    localparam int LIM_W         = SAMPLE_BITS - 1;
    localparam int ACC_W         = SAMPLE_BITS + FRAC_BITS;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;

    // The block ignores this opcode.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [OP_W-1:0]               opcode;
        logic signed [SAMPLE_BITS-1:0] measured;
        logic signed [SAMPLE_BITS-1:0] setpoint;
    } sample_t;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [WR_W-1:0]      wr_data;

    pidc_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
    pidc_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) res_if ();

    pid_controller_clamped #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample   (smp_if),
        .result   (res_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Controller copy: registers and loop state.
    logic [GAIN_W-1:0]             kp, ki, kd;
    logic signed [SAMPLE_BITS-1:0] ffwd;
    logic [LIM_W-1:0]              lim_meas, lim_sp, lim_integ, lim_out;
    logic signed [SAMPLE_BITS-1:0] prev_meas;
    logic signed [ACC_W-1:0]       integ_acc;

    sample_t                       pending_samples[$];
    sample_t                       on_bus;
    logic signed [SAMPLE_BITS-1:0] expected_drive[$];
    logic signed [SAMPLE_BITS-1:0] want_drive;

    int n_queued, n_accepted, n_steps, n_checked, n_errors, n_settings;
    int src_idle_pct, sink_idle_pct, src_gap, sink_gap, quiet_cycles;
    int walk_level;

    function automatic longint clamp_sym(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // Advances the controller copy by one sample and queues the drive it gives.
    // Arithmetic right shifts of signed values round toward minus infinity.
    function automatic void pid_predict(input sample_t s);
        longint m, sp, err, vel, acc, p, i, d, y;
        case (s.opcode)
            OP_CLR_INTEG:
                integ_acc = '0;
            OP_LOAD_MEAS:
            begin
                integ_acc = '0;
                prev_meas = s.measured;
            end
            OP_STEP:
            begin
                m   = clamp_sym(longint'(s.measured), longint'(lim_meas));
                sp  = clamp_sym(longint'(s.setpoint), longint'(lim_sp));
                err = sp - m;
                vel = m - longint'(prev_meas);
                prev_meas = m[SAMPLE_BITS-1:0];
                acc = clamp_sym(longint'(integ_acc) + err * longint'(ki),
                                longint'(lim_integ) <<< FRAC_BITS);
                integ_acc = acc[ACC_W-1:0];
                p = (err * longint'(kp)) >>> FRAC_BITS;
                i = acc >>> FRAC_BITS;
                d = (vel * longint'(kd)) >>> FRAC_BITS;
                y = clamp_sym(p + i - d + longint'(ffwd), longint'(lim_out));
                expected_drive.push_back(y[SAMPLE_BITS-1:0]);
                n_steps++;
            end
            default:
                ;
        endcase
    endfunction

    // Sample driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_if.valid    <= 1'b0;
            smp_if.opcode   <= OP_STEP;
            smp_if.measured <= '0;
            smp_if.setpoint <= '0;
        end
        else
        begin
            if (smp_if.valid && smp_if.ready)
            begin
                pid_predict(on_bus);
                n_accepted++;
            end
            if (!smp_if.valid || smp_if.ready)
            begin
                if (src_gap == 0 && $urandom_range(99) < src_idle_pct)
                    src_gap = $urandom_range(1, 7);
                if (src_gap > 0 || pending_samples.size() == 0)
                begin
                    if (src_gap > 0)
                        src_gap--;
                    smp_if.valid <= 1'b0;
                end
                else
                begin
                    on_bus = pending_samples.pop_front();
                    smp_if.valid    <= 1'b1;
                    smp_if.opcode   <= on_bus.opcode;
                    smp_if.measured <= on_bus.measured;
                    smp_if.setpoint <= on_bus.setpoint;
                end
            end
        end
    end

    // Result monitor, with random stalls on ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_drive.size() == 0)
                begin
                    $display("%0t: unexpected drive transfer, expected none, actual %0d",
                             $time, res_if.drive);
                    n_errors++;
                end
                else
                begin
                    want_drive = expected_drive.pop_front();
                    n_checked++;
                    if (res_if.drive !== want_drive)
                    begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $time, want_drive, res_if.drive);
                        n_errors++;
                    end
                end
            end
            if (sink_gap == 0 && $urandom_range(99) < sink_idle_pct)
                sink_gap = $urandom_range(1, 7);
            if (sink_gap > 0)
            begin
                sink_gap--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || wr_en || (smp_if.valid && smp_if.ready)
            || (res_if.valid && res_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_sample(input logic [OP_W-1:0] op, input int m, input int sp);
        sample_t s;
        s.opcode   = op;
        s.measured = m[SAMPLE_BITS-1:0];
        s.setpoint = sp[SAMPLE_BITS-1:0];
        pending_samples.push_back(s);
        n_queued++;
    endtask

    // Returns once every sample has been taken and every drive has come back,
    // and once a trailing reset opcode has had time to settle.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (n_accepted != n_queued || expected_drive.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WR_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            REG_PROP_GAIN:      kp        = data[GAIN_W-1:0];
            REG_INTEG_GAIN:     ki        = data[GAIN_W-1:0];
            REG_DERIV_GAIN:     kd        = data[GAIN_W-1:0];
            REG_FEED_FWD:       ffwd      = data[SAMPLE_BITS-1:0];
            REG_MEAS_LIMIT:     lim_meas  = data[LIM_W-1:0];
            REG_SETPOINT_LIMIT: lim_sp    = data[LIM_W-1:0];
            REG_INTEG_LIMIT:    lim_integ = data[LIM_W-1:0];
            REG_OUT_LIMIT:      lim_out   = data[LIM_W-1:0];
            default:
                ;
        endcase
    endtask

    // Writes all eight registers, then one random index above the last, which must be ignored.
    task automatic program_regs(input logic [WR_W-1:0] v_kp, v_ki, v_kd, v_ff,
                                v_lm, v_ls, v_li, v_lo);
        reg_write(REG_PROP_GAIN, v_kp);
        reg_write(REG_INTEG_GAIN, v_ki);
        reg_write(REG_DERIV_GAIN, v_kd);
        reg_write(REG_FEED_FWD, v_ff);
        reg_write(REG_MEAS_LIMIT, v_lm);
        reg_write(REG_SETPOINT_LIMIT, v_ls);
        reg_write(REG_INTEG_LIMIT, v_li);
        reg_write(REG_OUT_LIMIT, v_lo);
        reg_write(CFG_IDX_W'($urandom_range(int'(REG_OUT_LIMIT) + 1, (1 << CFG_IDX_W) - 1)),
                  WR_W'($urandom));
        wr_en <= 1'b0;
        n_settings++;
    endtask

    // Mix of full-range values, rail values, a slow walk that gives realistic
    // derivative terms, and small values that stay inside most limits.
    function automatic int rand_level();
        case ($urandom_range(0, 3))
            0:
                return int'($urandom_range(0, 65535)) - 32768;
            1:
                return $urandom_range(0, 1) ? 32767 : -32768;
            2:
            begin
                walk_level = int'(clamp_sym(walk_level + int'($urandom_range(0, 400)) - 200,
                                            30000));
                return walk_level;
            end
            default:
                return int'($urandom_range(0, 4000)) - 2000;
        endcase
    endfunction

    function automatic logic [WR_W-1:0] rand_gain();
        return WR_W'($urandom_range(0, 65535) >> $urandom_range(0, 12));
    endfunction

    // The top bit lies outside the limit registers and must be dropped.
    function automatic logic [WR_W-1:0] rand_limit();
        if ($urandom_range(0, 1))
            return WR_W'($urandom);
        return WR_W'($urandom_range(0, 3000) | ($urandom_range(0, 1) << LIM_W));
    endfunction

    task automatic run_phase(input int count);
        int r;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                queue_sample(OP_STEP, rand_level(), rand_level());
            else if (r < 88)
                queue_sample(OP_CLR_INTEG, rand_level(), rand_level());
            else if (r < 96)
                queue_sample(OP_LOAD_MEAS, rand_level(), rand_level());
            else
                queue_sample(OP_SPARE, rand_level(), rand_level());
        end
        wait_idle();
    endtask

    initial
    begin
        wr_en           = 1'b0;
        wr_index        = '0;
        wr_data         = '0;
        kp        = '0;
        ki        = '0;
        kd        = '0;
        ffwd      = '0;
        lim_meas  = '1;
        lim_sp    = '1;
        lim_integ = '1;
        lim_out   = '1;
        prev_meas = '0;
        integ_acc = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register values straight out of reset.
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        queue_sample(OP_STEP, 1234, -1234);
        queue_sample(OP_LOAD_MEAS, -77, 5);
        queue_sample(OP_STEP, 32767, -32768);
        wait_idle();

        // Moderate gains and limits; the measurement limit carries a stray top bit.
        program_regs(16'h0180, 16'h0040, 16'h0100, 16'hFFF9,
                     16'h83E8, 16'd2000, 16'd300, 16'd2500);
        queue_sample(OP_STEP, 0, 0);
        queue_sample(OP_STEP, 32767, -32768);
        queue_sample(OP_STEP, -32768, 32767);
        queue_sample(OP_STEP, 100, -101);
        // A held large error drives the integrator into its limit.
        queue_sample(OP_STEP, -2000, 2000);
        queue_sample(OP_STEP, -2000, 2000);
        queue_sample(OP_STEP, -2000, 2000);
        queue_sample(OP_CLR_INTEG, 123, 456);
        queue_sample(OP_STEP, 5, 7);
        // The load keeps the raw sample, so the next derivative sees the full jump.
        queue_sample(OP_LOAD_MEAS, -32768, 0);
        queue_sample(OP_STEP, 0, 0);
        queue_sample(OP_LOAD_MEAS, 32767, -1);
        queue_sample(OP_STEP, -1, -1);
        queue_sample(OP_SPARE, int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)));
        queue_sample(OP_STEP, 1, -1);
        queue_sample(OP_CLR_INTEG, -32768, 32767);
        queue_sample(OP_STEP, 32767, 32767);
        wait_idle();

        for (int ph = 0; ph < 5; ph++)
        begin
            src_idle_pct  = ph * 10;
            sink_idle_pct = 40 - ph * 10;
            program_regs(rand_gain(), rand_gain(), rand_gain(), WR_W'(rand_level()),
                         rand_limit(), rand_limit(), rand_limit(), rand_limit());
            run_phase(60);
        end

        src_idle_pct  = 25;
        sink_idle_pct = 25;
        program_regs('1, '1, '1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        run_phase(30);

        // All limits written as zero with only the dropped top bit set.
        program_regs(rand_gain(), rand_gain(), rand_gain(), 16'h7FFF,
                     16'h8000, 16'h8000, 16'h8000, 16'h8000);
        run_phase(30);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        program_regs(rand_gain(), rand_gain(), rand_gain(), WR_W'(rand_level()),
                     rand_limit(), rand_limit(), rand_limit(), rand_limit());
        run_phase(40);

        $display("Checked %0d drive values from %0d compute steps in %0d samples,",
                 n_checked, n_steps, n_accepted);
        $display("over %0d register settings with saturating gains, zero limits and idle bursts.",
                 n_settings);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/pidc_pkg.sv
hw/rtl/pidc_if.sv
hw/rtl/pidc_cfg_regs.sv
hw/rtl/pidc_core.sv
hw/rtl/pid_controller_clamped.sv
verif/tb_top.sv
